// ----- design/sap_pkg.sv -----
// ---------------------------------------------------------------------------
// Slot allocator package
// Field widths, operation and status codes, and the command token that walks
// the cell row.
// ---------------------------------------------------------------------------
package sap_pkg;

   localparam int OP_BITS       = 3;
   localparam int SLOT_BITS     = 6;
   localparam int POS_BITS      = 6;
   localparam int DATA_IN_BITS  = 32;
   localparam int STATUS_BITS   = 2;
   localparam int COUNT_BITS    = 7;
   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 48;

   localparam logic [OP_BITS-1:0] OP_ALLOC_ZERO = 3'd0;
   localparam logic [OP_BITS-1:0] OP_ALLOC_DATA = 3'd1;
   localparam logic [OP_BITS-1:0] OP_FREE       = 3'd2;
   localparam logic [OP_BITS-1:0] OP_READ       = 3'd3;
   localparam logic [OP_BITS-1:0] OP_LIVE_AT    = 3'd4;

   localparam logic [STATUS_BITS-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_MISS = 2'd2;

   // found: slot claimed (allocate), slot occupied (read), entry hit (live-at)
   // seen:  freed slot met in the live list at or before this cell
   typedef struct packed {
      logic                 active;
      logic [OP_BITS-1:0]   op;
      logic [SLOT_BITS-1:0] slot;
      logic [POS_BITS-1:0]  pos;
      logic                 seen;
      logic                 found;
   } wave_type;

endpackage

// ----- design/sap_cell.sv -----
// ---------------------------------------------------------------------------
// Slot allocator cell
// Holds the occupancy bit of slot INDEX and the live-list entry at position
// INDEX; updates both as the command token passes and hands it on.
// ---------------------------------------------------------------------------
module sap_cell #(
   parameter int SLOTS = 64,
   parameter int INDEX = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(SLOTS+1)-1:0]       count,
   input  sap_pkg::wave_type                wave_i,
   input  logic [$clog2(SLOTS)-1:0]         res_i,
   input  logic [$clog2(SLOTS)-1:0]         next_entry,
   input  logic                             app_we,
   input  logic [$clog2(SLOTS+1)-1:0]       app_pos,
   input  logic [$clog2(SLOTS)-1:0]         app_val,
   output sap_pkg::wave_type                wave_o,
   output logic [$clog2(SLOTS)-1:0]         res_o,
   output logic [$clog2(SLOTS)-1:0]         entry_o
);
   import sap_pkg::*;

   localparam int SW   = $clog2(SLOTS);
   localparam int CNTW = $clog2(SLOTS + 1);
   localparam int KW   = (SW > SLOT_BITS) ? SW : SLOT_BITS;
   localparam logic [KW-1:0]   IDX_K = KW'(INDEX);
   localparam logic [CNTW-1:0] IDX_C = CNTW'(INDEX);
   localparam logic [SW-1:0]   IDX_S = SW'(INDEX);

   wave_type        wave_ff, wave_in;
   logic [SW-1:0]   res_ff, res_in;
   logic [SW-1:0]   entry_ff, entry_in;
   logic            occ_ff, occ_in;
   logic            in_list, here_key, here_pos, entry_hit, seen;

   assign in_list   = IDX_C < count;
   assign here_key  = KW'(wave_i.slot) == IDX_K;
   assign here_pos  = KW'(wave_i.pos) == IDX_K;
   assign entry_hit = in_list && (KW'(entry_ff) == KW'(wave_i.slot));
   assign seen      = wave_i.seen || entry_hit;

   always_comb begin
      wave_in  = wave_i;
      res_in   = res_i;
      occ_in   = occ_ff;
      entry_in = entry_ff;
      if (wave_i.active) begin
         unique case (wave_i.op)
            OP_ALLOC_ZERO, OP_ALLOC_DATA: begin
               if (!wave_i.found && !occ_ff) begin
                  occ_in        = 1'b1;
                  wave_in.found = 1'b1;
                  res_in        = IDX_S;
               end
            end
            OP_FREE: begin
               if (here_key && occ_ff) begin
                  occ_in = 1'b0;
               end
               wave_in.seen = seen;
               if (seen && in_list) begin
                  entry_in = next_entry;
               end
            end
            OP_READ: begin
               if (here_key) begin
                  wave_in.found = occ_ff;
               end
            end
            OP_LIVE_AT: begin
               if (here_pos && in_list) begin
                  wave_in.found = 1'b1;
                  res_in        = entry_ff;
               end
            end
            default: begin
            end
         endcase
      end
      if (app_we && (app_pos == IDX_C)) begin
         entry_in = app_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= '0;
         occ_ff  <= 1'b0;
      end else begin
         wave_ff <= wave_in;
         occ_ff  <= occ_in;
      end
      res_ff   <= res_in;
      entry_ff <= entry_in;
   end

   assign wave_o  = wave_ff;
   assign res_o   = res_ff;
   assign entry_o = entry_ff;

endmodule

// ----- design/slot_allocator_with_live_list.sv -----
// ---------------------------------------------------------------------------
// Slot allocator with live list
// First-fit slot store with occupancy bits, an allocation-ordered live list
// and a payload memory; one result transfer per request transfer.
// ---------------------------------------------------------------------------
// One request is in work at a time. From its transfer to the next request
// transfer, the command token walks the row of SLOTS cells one cell per cycle
// (first-fit search, live-list lookup and compaction happen as it passes), is
// parked in a finish register at the end of the row and, once the output
// register is free, posts the result and the count, list and payload updates.
// The result waits in an output register, so the next request is taken while
// it is still pending. Payload reads use a registered memory read issued at
// the request transfer. Reset clears all occupancy bits at once.
module slot_allocator_with_live_list #(
   parameter int SLOTS        = 64,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // slot [5:0], position [11:6], payload_in [43:12], zero [47:44]
   input  logic [sap_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // operation [2:0]
   input  logic [sap_pkg::OP_BITS-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // slot_out [5:0], payload_out [37:6], live_count [44:38], zero [47:45]
   output logic [sap_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // status [1:0]
   output logic [sap_pkg::STATUS_BITS-1:0]     rsp_tuser
);
   import sap_pkg::*;

   localparam int SW   = $clog2(SLOTS);
   localparam int CNTW = $clog2(SLOTS + 1);
   localparam int KW   = (SW > SLOT_BITS) ? SW : SLOT_BITS;
   localparam int XW   = PAYLOAD_BITS + DATA_IN_BITS;

   logic                       accept;
   logic                       busy_ff, busy_in;
   logic [CNTW-1:0]            count_ff, count_in;
   logic [DATA_IN_BITS-1:0]    pin_ff;
   logic [PAYLOAD_BITS-1:0]    mem [SLOTS];
   logic [PAYLOAD_BITS-1:0]    rd_ff;
   logic [KW-1:0]              key_k;
   logic [SW-1:0]              rd_idx;

   wave_type                   wave_c [SLOTS+1];
   logic [SW-1:0]              res_c [SLOTS+1];
   logic [SW-1:0]              entry_c [SLOTS];

   wave_type                   fin_wave_ff;
   logic [SW-1:0]              fin_res_ff;
   logic                       fin_v_ff, fin_v_in;
   logic                       fin_go;

   logic [STATUS_BITS-1:0]     fin_status;
   logic [SW-1:0]              fin_slot;
   logic [DATA_IN_BITS-1:0]    fin_payload;
   logic                       fin_alloc, fin_free;
   logic [XW-1:0]              pin_ext, rd_ext;
   logic [PAYLOAD_BITS-1:0]    wdata;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]     rsp_status_ff;
   logic [SLOT_BITS-1:0]       rsp_slot_ff;
   logic [DATA_IN_BITS-1:0]    rsp_payload_ff;
   logic [COUNT_BITS-1:0]      rsp_count_ff;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign fin_go     = fin_v_ff && (!rsp_valid_ff || rsp_tready);

   assign wave_c[0] = '{active: accept,
                        op:     req_tuser,
                        slot:   req_tdata[SLOT_BITS-1:0],
                        pos:    req_tdata[SLOT_BITS+POS_BITS-1:SLOT_BITS],
                        seen:   1'b0,
                        found:  1'b0};
   assign res_c[0]  = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic [SW-1:0] nxt;
      if (i == SLOTS - 1) begin : g_tail
         assign nxt = entry_c[i];
      end else begin : g_body
         assign nxt = entry_c[i+1];
      end
      sap_cell #(
         .SLOTS (SLOTS),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .count      (count_ff),
         .wave_i     (wave_c[i]),
         .res_i      (res_c[i]),
         .next_entry (nxt),
         .app_we     (fin_go && fin_alloc),
         .app_pos    (count_ff),
         .app_val    (fin_res_ff),
         .wave_o     (wave_c[i+1]),
         .res_o      (res_c[i+1]),
         .entry_o    (entry_c[i])
      );
   end

   assign key_k   = KW'(req_tdata[SLOT_BITS-1:0]);
   assign rd_idx  = key_k[SW-1:0];
   assign pin_ext = XW'(pin_ff);
   assign rd_ext  = XW'(rd_ff);
   assign wdata   = (fin_wave_ff.op == OP_ALLOC_DATA) ? pin_ext[PAYLOAD_BITS-1:0] : '0;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[rd_idx];
      end
      if (fin_go && fin_alloc) begin
         mem[fin_res_ff] <= wdata;
      end
   end

   always_comb begin
      fin_status  = STATUS_MISS;
      fin_slot    = '0;
      fin_payload = '0;
      fin_alloc   = 1'b0;
      fin_free    = 1'b0;
      unique case (fin_wave_ff.op)
         OP_ALLOC_ZERO, OP_ALLOC_DATA: begin
            if (fin_wave_ff.found) begin
               fin_status = STATUS_OK;
               fin_slot   = fin_res_ff;
               fin_alloc  = 1'b1;
            end else begin
               fin_status = STATUS_FULL;
            end
         end
         OP_FREE: begin
            if (fin_wave_ff.seen) begin
               fin_status = STATUS_OK;
               fin_free   = 1'b1;
            end
         end
         OP_READ: begin
            if (fin_wave_ff.found) begin
               fin_status  = STATUS_OK;
               fin_payload = rd_ext[DATA_IN_BITS-1:0];
            end
         end
         OP_LIVE_AT: begin
            if (fin_wave_ff.found) begin
               fin_status = STATUS_OK;
               fin_slot   = fin_res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (fin_go && fin_alloc) begin
         count_in = count_ff + CNTW'(1);
      end else if (fin_go && fin_free) begin
         count_in = count_ff - CNTW'(1);
      end
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (fin_go) begin
         busy_in = 1'b0;
      end
      fin_v_in = fin_v_ff;
      if (wave_c[SLOTS].active) begin
         fin_v_in = 1'b1;
      end else if (fin_go) begin
         fin_v_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fin_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         fin_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         fin_v_ff     <= fin_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         pin_ff <= req_tdata[SLOT_BITS+POS_BITS+DATA_IN_BITS-1:SLOT_BITS+POS_BITS];
      end
      if (wave_c[SLOTS].active) begin
         fin_wave_ff <= wave_c[SLOTS];
         fin_res_ff  <= res_c[SLOTS];
      end
      if (fin_go) begin
         rsp_status_ff  <= fin_status;
         rsp_slot_ff    <= SLOT_BITS'(fin_slot);
         rsp_payload_ff <= fin_payload;
         rsp_count_ff   <= COUNT_BITS'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-SLOT_BITS-DATA_IN_BITS-COUNT_BITS){1'b0}},
                        rsp_count_ff, rsp_payload_ff, rsp_slot_ff};

endmodule

// ----- design/sap_checker.sv -----
// ---------------------------------------------------------------------------
// Slot allocator checker
// Port-level properties of the slot allocator, bound to the top level.
// ---------------------------------------------------------------------------
module sap_checker #(
   parameter int SLOTS = 64
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [sap_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input logic [sap_pkg::OP_BITS-1:0]         req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [sap_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input logic [sap_pkg::STATUS_BITS-1:0]     rsp_tuser
);
   import sap_pkg::*;

   localparam bit                    COUNT_FITS = SLOTS < 128;
   localparam logic [COUNT_BITS-1:0] SLOTS_K    = COUNT_BITS'(SLOTS);

   logic [COUNT_BITS-1:0] live;
   logic                  req_xfer;

   assign live     = rsp_tdata[44:38];
   assign req_xfer = req_tvalid && req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("request taken while another is in work");

   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata[37:0] == '0)
      else $error("failed result carries a slot or payload");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_FULL |-> !COUNT_FITS || live == SLOTS_K)
      else $error("full reported below capacity");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !COUNT_FITS || live <= SLOTS_K)
      else $error("live count above capacity");

endmodule

bind slot_allocator_with_live_list sap_checker #(.SLOTS(SLOTS)) u_sap_checker (.*);

// ----- sim/slot_allocator_with_live_list_tb.sv -----
// ---------------------------------------------------------------------------
// Slot allocator with live list testbench
// Directed table of requests after reset, a fill to full, then random episodes
// with shifting allocate/free balance. Each response transfer is checked field
// by field against the typed table or an in-bench slot-store predictor. Random
// stalls on both streams, one long response hold-off and one drain pause.
// ---------------------------------------------------------------------------
module slot_allocator_with_live_list_tb;
   import sap_pkg::*;

   localparam int SLOTS         = 64;
   localparam int PAYLOAD_BITS  = 32;
   localparam int SW            = $clog2(SLOTS);
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int HOLD_CYCLES   = 600;
   localparam int HOLD_AFTER    = 400;
   localparam int EPISODES      = 20;
   localparam int EPISODE_ITEMS = 90;
   localparam int SETTLE_CYCLES = SLOTS + 8;

   localparam logic [OP_BITS-1:0] OP_RSVD5 = 3'd5;
   localparam logic [OP_BITS-1:0] OP_RSVD6 = 3'd6;
   localparam logic [OP_BITS-1:0] OP_RSVD7 = 3'd7;

   typedef struct packed {
      logic [STATUS_BITS-1:0]  status;
      logic [SLOT_BITS-1:0]    slot;
      logic [PAYLOAD_BITS-1:0] payload;
      logic [COUNT_BITS-1:0]   live;
   } reply_type;

   typedef struct {
      logic [OP_BITS-1:0]      op;
      logic [SLOT_BITS-1:0]    slot;
      logic [POS_BITS-1:0]     pos;
      logic [PAYLOAD_BITS-1:0] payload;
      bit                      typed;
      reply_type               reply;
   } stim_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic [OP_BITS-1:0]       req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [STATUS_BITS-1:0]   rsp_tuser;

   // predictor state
   logic                    slot_busy  [SLOTS];
   logic [SLOT_BITS-1:0]    live_order [SLOTS];
   logic [PAYLOAD_BITS-1:0] slot_data  [SLOTS];
   int                      live_total;

   reply_type    pending_replies[$];
   stim_row_type directed_rows[$];
   reply_type    arrived;
   reply_type    wanted;
   int           errors = 0;
   int           accepted;
   int           cycle_count = 0;
   bit           calm;
   bit           hold_done;

   slot_allocator_with_live_list #(
      .SLOTS        (SLOTS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic reply_type allocator_outcome(input logic [OP_BITS-1:0] op,
                                                   input logic [SLOT_BITS-1:0] slot,
                                                   input logic [POS_BITS-1:0] pos,
                                                   input logic [PAYLOAD_BITS-1:0] payload);
      reply_type r;
      int        hit;
      int        p;
      r = '0;
      case (op)
         OP_ALLOC_ZERO, OP_ALLOC_DATA: begin
            if (live_total >= SLOTS) begin
               r.status = STATUS_FULL;
            end else begin
               hit = 0;
               while (slot_busy[hit[SW-1:0]]) hit++;
               slot_busy[hit[SW-1:0]] = 1'b1;
               slot_data[hit[SW-1:0]] = (op == OP_ALLOC_DATA) ? payload : '0;
               live_order[live_total[SW-1:0]] = hit[SLOT_BITS-1:0];
               live_total++;
               r.status = STATUS_OK;
               r.slot = hit[SLOT_BITS-1:0];
            end
         end
         OP_FREE: begin
            hit = live_total;
            for (p = live_total - 1; p >= 0; p--) begin
               if (live_order[p[SW-1:0]] == slot) hit = p;
            end
            if (hit == live_total) begin
               r.status = STATUS_MISS;
            end else begin
               for (p = hit; p < live_total - 1; p++)
                  live_order[p[SW-1:0]] = live_order[SW'(p + 1)];
               live_total--;
               slot_busy[slot] = 1'b0;
               r.status = STATUS_OK;
            end
         end
         OP_READ: begin
            if (slot_busy[slot]) begin
               r.status = STATUS_OK;
               r.payload = slot_data[slot];
            end else begin
               r.status = STATUS_MISS;
            end
         end
         OP_LIVE_AT: begin
            if (int'(pos) < live_total) begin
               r.status = STATUS_OK;
               r.slot = live_order[pos];
            end else begin
               r.status = STATUS_MISS;
            end
         end
         default: begin
            r.status = STATUS_MISS;
         end
      endcase
      r.live = live_total[COUNT_BITS-1:0];
      return r;
   endfunction

   // one request transfer; the expectation is queued at the accepting edge
   task automatic send_item(input logic [OP_BITS-1:0] op,
                            input logic [SLOT_BITS-1:0] slot,
                            input logic [POS_BITS-1:0] pos,
                            input logic [PAYLOAD_BITS-1:0] payload,
                            input bit typed,
                            input reply_type typed_reply);
      reply_type predicted;
      req_tuser  <= op;
      req_tdata  <= {4'b0000, payload, pos, slot};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accepted++;
      predicted = allocator_outcome(op, slot, pos, payload);
      pending_replies.push_back(typed ? typed_reply : predicted);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic random_item(input int alloc_pct);
      logic [OP_BITS-1:0]      op;
      logic [SLOT_BITS-1:0]    slot;
      logic [POS_BITS-1:0]     pos;
      logic [PAYLOAD_BITS-1:0] payload;
      int                      pick;
      slot = SLOT_BITS'($urandom_range(0, SLOTS - 1));
      pos = POS_BITS'($urandom_range(0, 63));
      payload = $urandom;
      if ($urandom_range(0, 7) == 0) payload = $urandom_range(0, 1) ? '1 : '0;
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
         op = $urandom_range(0, 1) ? OP_ALLOC_DATA : OP_ALLOC_ZERO;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            op = OP_FREE;
            if (live_total > 0 && $urandom_range(0, 6) != 0)
               slot = live_order[SW'($urandom_range(0, live_total - 1))];
         end else if (pick < 70) begin
            op = OP_READ;
            if (live_total > 0 && $urandom_range(0, 4) != 0)
               slot = live_order[SW'($urandom_range(0, live_total - 1))];
         end else if (pick < 95) begin
            op = OP_LIVE_AT;
            if (live_total > 0 && $urandom_range(0, 4) != 0)
               pos = POS_BITS'($urandom_range(0, live_total - 1));
         end else begin
            case ($urandom_range(0, 2))
               0: op = OP_RSVD5;
               1: op = OP_RSVD6;
               default: op = OP_RSVD7;
            endcase
         end
      end
      send_item(op, slot, pos, payload, 1'b0, '0);
   endtask

   task automatic add_row(input logic [OP_BITS-1:0] op, input logic [SLOT_BITS-1:0] slot,
                          input logic [POS_BITS-1:0] pos,
                          input logic [PAYLOAD_BITS-1:0] payload, input bit typed,
                          input logic [STATUS_BITS-1:0] st, input logic [SLOT_BITS-1:0] so,
                          input logic [PAYLOAD_BITS-1:0] po,
                          input logic [COUNT_BITS-1:0] cnt);
      stim_row_type row;
      row.op = op;
      row.slot = slot;
      row.pos = pos;
      row.payload = payload;
      row.typed = typed;
      row.reply = '{status: st, slot: so, payload: po, live: cnt};
      directed_rows.push_back(row);
   endtask

   initial begin : sender
      int alloc_pct;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_ALLOC_ZERO;
      accepted = 0;
      calm = 1'b0;
      live_total = 0;
      for (int s = 0; s < SLOTS; s++) begin
         slot_busy[s[SW-1:0]] = 1'b0;
         live_order[s[SW-1:0]] = '0;
         slot_data[s[SW-1:0]] = '0;
      end

      //      op             slot pos payload        typed status       slot payload       count
      add_row(OP_READ,       0,   0,  32'h0,         1, STATUS_MISS, 0,   32'h0,         0);
      add_row(OP_LIVE_AT,    0,   0,  32'h0,         1, STATUS_MISS, 0,   32'h0,         0);
      add_row(OP_FREE,       0,   0,  32'h0,         1, STATUS_MISS, 0,   32'h0,         0);
      add_row(OP_RSVD5,      0,   0,  32'h0,         1, STATUS_MISS, 0,   32'h0,         0);
      add_row(OP_RSVD6,      63,  63, 32'hFFFF_FFFF, 1, STATUS_MISS, 0,   32'h0,         0);
      add_row(OP_RSVD7,      21,  42, 32'hA5A5_5A5A, 1, STATUS_MISS, 0,   32'h0,         0);
      add_row(OP_ALLOC_ZERO, 63,  63, 32'hFFFF_FFFF, 1, STATUS_OK,   0,   32'h0,         1);
      add_row(OP_ALLOC_DATA, 0,   0,  32'hFFFF_FFFF, 1, STATUS_OK,   1,   32'h0,         2);
      add_row(OP_READ,       1,   0,  32'h0,         1, STATUS_OK,   0,   32'hFFFF_FFFF, 2);
      add_row(OP_READ,       0,   0,  32'h0,         1, STATUS_OK,   0,   32'h0,         2);
      add_row(OP_LIVE_AT,    0,   1,  32'h0,         1, STATUS_OK,   1,   32'h0,         2);
      add_row(OP_LIVE_AT,    0,   63, 32'h0,         1, STATUS_MISS, 0,   32'h0,         2);
      add_row(OP_READ,       63,  0,  32'h0,         1, STATUS_MISS, 0,   32'h0,         2);
      add_row(OP_FREE,       63,  0,  32'h0,         1, STATUS_MISS, 0,   32'h0,         2);
      add_row(OP_FREE,       0,   0,  32'h0,         1, STATUS_OK,   0,   32'h0,         1);
      add_row(OP_LIVE_AT,    0,   0,  32'h0,         1, STATUS_OK,   1,   32'h0,         1);
      add_row(OP_ALLOC_DATA, 0,   0,  32'h0000_0001, 1, STATUS_OK,   0,   32'h0,         2);
      add_row(OP_LIVE_AT,    0,   1,  32'h0,         1, STATUS_OK,   0,   32'h0,         2);
      add_row(OP_READ,       0,   0,  32'h0,         1, STATUS_OK,   0,   32'h0000_0001, 2);
      add_row(OP_ALLOC_DATA, 0,   0,  32'h8000_0000, 0, STATUS_OK,   0,   32'h0,         0);
      add_row(OP_FREE,       1,   0,  32'h0,         0, STATUS_OK,   0,   32'h0,         0);
      add_row(OP_LIVE_AT,    0,   0,  32'h0,         0, STATUS_OK,   0,   32'h0,         0);
      add_row(OP_LIVE_AT,    0,   1,  32'h0,         0, STATUS_OK,   0,   32'h0,         0);
      add_row(OP_READ,       2,   0,  32'h0,         0, STATUS_OK,   0,   32'h0,         0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].slot, directed_rows[i].pos,
                   directed_rows[i].payload, directed_rows[i].typed, directed_rows[i].reply);

      // fill to capacity, push allocations against a full store, then non-allocating requests
      while (live_total < SLOTS) random_item(100);
      repeat (4) random_item(100);
      repeat (6) random_item(0);

      for (int e = 0; e < EPISODES; e++) begin
         if (e == EPISODES / 2) begin
            req_tvalid <= 1'b0;
            while (pending_replies.size() != 0) @(posedge clock);
         end
         calm = (e == EPISODES - 1);
         case ($urandom_range(0, 2))
            0: alloc_pct = 15;
            1: alloc_pct = 50;
            default: alloc_pct = 85;
         endcase
         repeat (EPISODE_ITEMS) random_item(alloc_pct);
      end

      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : receiver
      rsp_tready = 1'b0;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && accepted >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         arrived.status  = rsp_tuser;
         arrived.slot    = rsp_tdata[5:0];
         arrived.payload = rsp_tdata[37:6];
         arrived.live    = rsp_tdata[44:38];
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected response transfer, status %0d slot %0d",
                     $time, arrived.status, arrived.slot);
            $display("%0t: unexpected response transfer, payload %h count %0d",
                     $time, arrived.payload, arrived.live);
            errors++;
         end else begin
            wanted = pending_replies.pop_front();
            if (arrived.status !== wanted.status) begin
               $display("%0t: status expected %0d actual %0d", $time, wanted.status,
                        arrived.status);
               errors++;
            end
            if (arrived.slot !== wanted.slot) begin
               $display("%0t: slot_out expected %0d actual %0d", $time, wanted.slot,
                        arrived.slot);
               errors++;
            end
            if (arrived.payload !== wanted.payload) begin
               $display("%0t: payload_out expected %h actual %h", $time, wanted.payload,
                        arrived.payload);
               errors++;
            end
            if (arrived.live !== wanted.live) begin
               $display("%0t: live_count expected %0d actual %0d", $time, wanted.live,
                        arrived.live);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d responses outstanding", $time, pending_replies.size());
         $display("status: fail");
         $finish;
      end
   end

endmodule

// ----- filelist.f -----
design/sap_pkg.sv
design/sap_cell.sv
design/slot_allocator_with_live_list.sv
design/sap_checker.sv
sim/slot_allocator_with_live_list_tb.sv
